// ===== src/lprt_pkg.sv =====
`default_nettype none
package lprt_pkg;

    // Line store geometry.
    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int MAX_ROWS  = 4096;
    localparam int ROW_W     = $clog2(MAX_ROWS);

    // Configuration registers are 13 bits wide.
    localparam int REG_W     = 13;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [REG_W-1:0] REG_ONE      = REG_W'(1);
    localparam logic [REG_W-1:0] WIDTH_LIMIT  = REG_W'(MAX_WIDTH);
    localparam logic [REG_W-1:0] HEIGHT_LIMIT = REG_W'(MAX_ROWS);

    // One pixel in the color-transformed domain (red and blue minus green).
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    localparam int PIXEL_W = $bits(pixel_t);

    // Input word.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [7:0] residual_alpha;
        logic [7:0] residual_red;
        logic [7:0] residual_green;
        logic [7:0] residual_blue;
        logic       row_end;
        logic       image_end;
    } out_word_t;

    // Position of the current pixel as seen by the predictor.
    typedef struct packed {
        logic first_row;
        logic first_col;
    } pos_t;

endpackage
`default_nettype wire

// ===== src/lprt_line_ram.sv =====
`default_nettype none
module lprt_line_ram #(
    parameter int DEPTH  = 4096,
    parameter int DATA_W = 24,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; a read of the address being written returns the new data.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data <= wr_data;
        end
        else
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== src/lprt_predict.sv =====
`default_nettype none
module lprt_predict (
    input  wire lprt_pkg::pixel_t cur,
    input  wire lprt_pkg::pixel_t left,
    input  wire lprt_pkg::pixel_t top,
    input  wire lprt_pkg::pixel_t upper_left,
    input  wire lprt_pkg::pos_t   pos,
    output lprt_pkg::pixel_t      residual
);
    import lprt_pkg::*;

    // Clamp of left + top - top_left to 0..255 on one channel.
    function automatic logic [7:0] clamp_chan(input logic [7:0] l,
                                              input logic [7:0] t,
                                              input logic [7:0] tl);
        logic [9:0] v;
        begin
            v = {2'b00, l} + {2'b00, t} - {2'b00, tl};
            if (v[9])
            begin
                clamp_chan = 8'h00;
            end
            else if (v[8])
            begin
                clamp_chan = 8'hFF;
            end
            else
            begin
                clamp_chan = v[7:0];
            end
        end
    endfunction

    pixel_t pred;

    always_comb
    begin
        if (pos.first_row)
        begin
            pred = pos.first_col ? '0 : left;
        end
        else if (pos.first_col)
        begin
            pred = top;
        end
        else
        begin
            pred.red   = clamp_chan(left.red,   top.red,   upper_left.red);
            pred.green = clamp_chan(left.green, top.green, upper_left.green);
            pred.blue  = clamp_chan(left.blue,  top.blue,  upper_left.blue);
        end
    end

    assign residual.red   = cur.red   - pred.red;
    assign residual.green = cur.green - pred.green;
    assign residual.blue  = cur.blue  - pred.blue;

endmodule
`default_nettype wire

// ===== src/lossless_pixel_residual_transform_unit.sv =====
`default_nettype none
// Lossless pixel residual transform: subtract-green followed by the clamped
// add-subtract predictor, one RGB pixel in, one ARGB residual word out.
//
// Pixel channel: a word moves when pixel_valid is high and pixel_stall is low.
// Pixels arrive in raster order; the block tracks row and column itself and
// flags the last pixel of each row and of the image in the result word.
// Residual channel: a word moves when residual_valid is high and
// residual_stall is low. Configuration channel: cfg_ready is always high;
// index 0 writes image_width, index 1 writes image_height, other indexes are
// ignored. Write configuration only while no pixel is in flight.
//
// The result word is registered and offered in the cycle after its pixel is
// accepted. Throughput is one pixel per cycle while the receiver does not stall,
// held by the line store, which has one write port for the current column and
// one registered read port that fetches the next column's upper neighbor ahead.
// While the receiver stalls, the result register holds its word and
// pixel_stall rises so that no pixel is taken until the word is gone.
// Reset clears position, neighbor registers and the result valid, and sets
// both size registers to 1; the line store is not cleared. The user must see that
// each entry is read only after the row above wrote it; the block does not enforce it.
module lossless_pixel_residual_transform_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         pixel_valid,
    output logic                              pixel_stall,
    input  wire lprt_pkg::in_word_t           pixel,
    output logic                              residual_valid,
    input  wire logic                         residual_stall,
    output lprt_pkg::out_word_t               residual,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [lprt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lprt_pkg::REG_W-1:0]   cfg_data
);
    import lprt_pkg::*;

    logic [REG_W-1:0] width_reg;
    logic [REG_W-1:0] height_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    pixel_t           left_reg;
    pixel_t           upper_left_reg;
    logic             residual_valid_reg;
    out_word_t        residual_reg;

    logic             accept;
    pixel_t           cur;
    pixel_t           top;
    pixel_t           diff;
    pos_t             pos;
    logic [REG_W-1:0] width_eff;
    logic [REG_W-1:0] height_eff;
    logic             last_col;
    logic             last_row;

    // Configuration registers; the port never pushes back.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= REG_ONE;
            height_reg <= REG_ONE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // A zero size behaves as one, an oversized one as the limit.
    always_comb
    begin
        if (width_reg == '0)
        begin
            width_eff = REG_ONE;
        end
        else if (width_reg > WIDTH_LIMIT)
        begin
            width_eff = WIDTH_LIMIT;
        end
        else
        begin
            width_eff = width_reg;
        end

        if (height_reg == '0)
        begin
            height_eff = REG_ONE;
        end
        else if (height_reg > HEIGHT_LIMIT)
        begin
            height_eff = HEIGHT_LIMIT;
        end
        else
        begin
            height_eff = height_reg;
        end
    end

    // The output register takes a new word when empty or when its word leaves.
    assign pixel_stall = residual_valid_reg && residual_stall;
    assign accept      = pixel_valid && !pixel_stall;

    // Subtract-green color transform.
    assign cur.red   = pixel.red  - pixel.green;
    assign cur.green = pixel.green;
    assign cur.blue  = pixel.blue - pixel.green;

    assign pos.first_row = (row_reg == '0);
    assign pos.first_col = (col_reg == '0);

    // The position may sit past the last column or row after a size change;
    // such a pixel still ends the row or image.
    assign last_col = ((REG_W'(col_reg) + REG_ONE) >= width_eff);
    assign last_row = ((REG_W'(row_reg) + REG_ONE) >= height_eff);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : ROW_W'(REG_W'(row_reg) + REG_ONE);
            end
            else
            begin
                col_next = COL_W'(REG_W'(col_reg) + REG_ONE);
            end
        end
    end

    // The read port always fetches the entry of the column that comes next,
    // so top holds the upper neighbor of the current column.
    lprt_line_ram #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (PIXEL_W)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (cur),
        .rd_addr (col_next),
        .rd_data (top)
    );

    lprt_predict u_predict (
        .cur        (cur),
        .left       (left_reg),
        .top        (top),
        .upper_left (upper_left_reg),
        .pos        (pos),
        .residual   (diff)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            left_reg       <= '0;
            upper_left_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (accept)
            begin
                left_reg       <= cur;
                upper_left_reg <= top;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            residual_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            residual_valid_reg <= 1'b1;
        end
        else if (!residual_stall)
        begin
            residual_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            residual_reg.residual_alpha <= 8'h00;
            residual_reg.residual_red   <= diff.red;
            residual_reg.residual_green <= diff.green;
            residual_reg.residual_blue  <= diff.blue;
            residual_reg.row_end        <= last_col;
            residual_reg.image_end      <= last_col && last_row;
        end
    end

    assign residual_valid = residual_valid_reg;
    assign residual       = residual_reg;

    // A stall toward the source only ever comes from a full, blocked result register.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (residual_valid_reg && residual_stall))
        else $error("pixel_stall raised without a blocked result");

    // Every accepted pixel shows up as a valid result on the next cycle.
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> residual_valid_reg)
        else $error("accepted pixel produced no result");

    // The last pixel of the image is always also the last of its row.
    a_image_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (residual_valid_reg && residual_reg.image_end) |-> residual_reg.row_end)
        else $error("image_end without row_end");

    // After a row ends the column returns to zero.
    a_row_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_col) |=> (col_reg == '0))
        else $error("column did not wrap at row end");

    // After the image ends the position is back at the first pixel.
    a_image_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_col && last_row) |=> (row_reg == '0 && col_reg == '0))
        else $error("position did not wrap at image end");

endmodule
`default_nettype wire

// ===== tb/lossless_pixel_residual_transform_unit_test.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the lossless pixel residual transform unit.
//
// Pixels are pushed into a queue by the main initial block, one phase at a time. A clocked
// driver offers them on the pixel channel. A clocked monitor does two jobs at each edge.
// For every accepted pixel word it runs a local copy of the transform and files the
// expected residual word. For every accepted residual word it compares the word, field by
// field, with the oldest one on file.
//
// The image size registers are only rewritten once the block has drained. A width that
// grows in the middle of an image is limited to what the line store already holds, so
// that no row ever reads an entry that no earlier row wrote.
module lossless_pixel_residual_transform_unit_test;
    import lprt_pkg::*;

    localparam int CHANNEL_MAX     = 255;
    localparam int RANDOM_PIXELS   = 1600;
    localparam int LONG_ROW_PIXELS = 200;
    localparam int WHOLE_IMAGE_CAP = 600;
    localparam int TAIL_CYCLES     = 4;

    localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_INDEX = CFG_IMAGE_HEIGHT + 1'b1;
    localparam logic [CFG_IDX_W-1:0] LAST_SPARE_INDEX  = '1;
    localparam logic [REG_W-1:0]     REG_MAX           = '1;
    localparam pixel_t               OPAQUE_BLACK      = '0;

    // Idling modes, as percentages per cycle: none, slow sender, slow receiver, both light.
    localparam int SENDER_IDLE_PCT    [4] = '{0, 80, 0, 8};
    localparam int RECEIVER_STALL_PCT [4] = '{0, 0, 80, 8};

    // A hand-picked 3 x 2 image followed by half of another one. The second row drives
    // the gradient predictor into its lower clamp on red and blue.
    localparam logic [PIXEL_W-1:0] GRID_PIXELS [9] = '{
        24'hFF00FF, 24'h00FF00, 24'h808080,
        24'h000000, 24'hFFFFFF, 24'hC80A5A,
        24'h01FE7F, 24'hFE0180, 24'h7F7F7F
    };

    typedef struct {
        in_word_t word;
        bit       drain_first;
    } pending_pixel_t;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 pixel_valid    = 1'b0;
    logic                 pixel_stall;
    in_word_t             pixel          = '0;
    logic                 residual_valid;
    logic                 residual_stall = 1'b0;
    out_word_t            residual;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [REG_W-1:0]     cfg_data       = '0;

    pending_pixel_t pixel_queue [$];
    out_word_t      residual_due [$];
    int unsigned    pixels_taken       = 0;
    int unsigned    residuals_taken    = 0;
    int             mismatch_count     = 0;
    int             sender_idle_pct    = 0;
    int             receiver_stall_pct = 0;
    in_word_t       last_queued        = '0;

    // Local copy of the transform state. The upper row is only ever read where it was
    // written, so it needs no reset value.
    pixel_t           upper_row [MAX_WIDTH];
    pixel_t           west_px        = '0;
    pixel_t           northwest_px   = '0;
    int unsigned      column_at      = 0;
    int unsigned      row_at         = 0;
    int unsigned      upper_row_fill = 0;
    logic [REG_W-1:0] width_setting  = REG_ONE;
    logic [REG_W-1:0] height_setting = REG_ONE;

    lossless_pixel_residual_transform_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixel_valid    (pixel_valid),
        .pixel_stall    (pixel_stall),
        .pixel          (pixel),
        .residual_valid (residual_valid),
        .residual_stall (residual_stall),
        .residual       (residual),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // A size register of zero acts as one, and anything past the limit acts as the limit.
    function automatic int unsigned span(input logic [REG_W-1:0] value, input int unsigned limit);
        if (value == '0)
            return 1;
        if (value > limit)
            return limit;
        return 32'(value);
    endfunction

    // Gradient prediction for one channel: west plus north minus northwest, held to 0..255.
    function automatic logic [7:0] gradient(input logic [7:0] w, input logic [7:0] n,
                                            input logic [7:0] nw);
        int sum;
        sum = int'(w) + int'(n) - int'(nw);
        if (sum < 0)
            return 8'h00;
        if (sum > CHANNEL_MAX)
            return 8'hFF;
        return sum[7:0];
    endfunction

    // Works out the residual word for one pixel and advances the raster position.
    task automatic predict_residual(input in_word_t px, output out_word_t res);
        pixel_t      cur;
        pixel_t      above;
        pixel_t      guess;
        int unsigned row_len;
        int unsigned row_count;
        logic        last_col;
        logic        last_row;

        // Subtract green first; later arithmetic wraps at 8 bits, but the gradient is clamped.
        cur.red   = px.red - px.green;
        cur.green = px.green;
        cur.blue  = px.blue - px.green;
        above     = upper_row[column_at];
        row_len   = span(width_setting, MAX_WIDTH);
        row_count = span(height_setting, MAX_ROWS);

        if (row_at == 0)
            guess = (column_at == 0) ? OPAQUE_BLACK : west_px;
        else if (column_at == 0)
            guess = above;
        else
        begin
            guess.red   = gradient(west_px.red,   above.red,   northwest_px.red);
            guess.green = gradient(west_px.green, above.green, northwest_px.green);
            guess.blue  = gradient(west_px.blue,  above.blue,  northwest_px.blue);
        end

        // Alpha is always 255 and always predicted as 255.
        res.residual_alpha = 8'h00;
        res.residual_red   = cur.red   - guess.red;
        res.residual_green = cur.green - guess.green;
        res.residual_blue  = cur.blue  - guess.blue;

        northwest_px         = above;
        west_px              = cur;
        upper_row[column_at] = cur;
        if (column_at >= upper_row_fill)
            upper_row_fill = column_at + 1;

        // The comparisons use at-or-beyond so that a size shrunk mid-image ends the row
        // or the image on the current pixel.
        last_col = (column_at + 1 >= row_len);
        last_row = (row_at + 1 >= row_count);
        if (last_col)
        begin
            column_at = 0;
            row_at    = last_row ? 0 : row_at + 1;
        end
        else
            column_at++;

        res.row_end   = last_col;
        res.image_end = last_col && last_row;
    endtask

    task automatic note_error(input string msg);
        mismatch_count++;
        $display("%0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
            note_error($sformatf("%s expected %h, got %h", name, want, got));
    endtask

    // Driver. A new word is offered only when the previous one is gone. A word marked
    // drain_first waits until every residual word owed so far has been taken.
    always @(posedge clk)
    begin
        if (rst_n && (!pixel_valid || !pixel_stall))
        begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
                (!pixel_queue[0].drain_first ||
                 (!pixel_valid && pixels_taken == residuals_taken)))
            begin
                pixel       <= pixel_queue[0].word;
                pixel_valid <= 1'b1;
                void'(pixel_queue.pop_front());
            end
            else
                pixel_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        residual_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Monitor and scoreboard. Both channels are sampled here at the clock edge.
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n)
        begin
            if (pixel_valid && !pixel_stall)
            begin
                predict_residual(pixel, want);
                residual_due = {residual_due, want};
                pixels_taken <= pixels_taken + 1;
            end
            if (residual_valid && !residual_stall)
            begin
                residuals_taken <= residuals_taken + 1;
                if (residual_due.size() == 0)
                    note_error($sformatf("residual word expected none, got %h", residual));
                else
                begin
                    want = residual_due.pop_front();
                    compare_field("residual_alpha", want.residual_alpha, residual.residual_alpha);
                    compare_field("residual_red",   want.residual_red,   residual.residual_red);
                    compare_field("residual_green", want.residual_green, residual.residual_green);
                    compare_field("residual_blue",  want.residual_blue,  residual.residual_blue);
                    compare_field("row_end",        8'(want.row_end),    8'(residual.row_end));
                    compare_field("image_end",      8'(want.image_end),  8'(residual.image_end));
                end
            end
        end
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [REG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == CFG_IMAGE_WIDTH)
            width_setting = value;
        else if (index == CFG_IMAGE_HEIGHT)
            height_setting = value;
    endtask

    // Below the first row, a wider setting may only reach columns that the line store
    // already holds.
    task automatic write_width(input logic [REG_W-1:0] value);
        if (row_at != 0 && span(value, MAX_WIDTH) > upper_row_fill)
            value = REG_W'(upper_row_fill);
        write_register(CFG_IMAGE_WIDTH, value);
    endtask

    task automatic write_spare_register();
        write_register(CFG_IDX_W'($urandom_range(FIRST_SPARE_INDEX, LAST_SPARE_INDEX)),
                       REG_W'($urandom));
    endtask

    task automatic queue_pixel(input in_word_t word, input bit drain_first);
        pending_pixel_t item;
        item.word        = word;
        item.drain_first = drain_first;
        pixel_queue      = {pixel_queue, item};
        last_queued      = word;
    endtask

    function automatic logic [7:0] random_channel();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // A quarter of the pixels stay close to the previous one, as in a real photo,
    // which keeps the residuals near zero and makes wrap-around at 0 and 255 common.
    function automatic in_word_t random_pixel();
        in_word_t px;
        if ($urandom_range(3) == 0)
        begin
            px.red   = last_queued.red   + 8'($urandom_range(6)) - 8'd3;
            px.green = last_queued.green + 8'($urandom_range(6)) - 8'd3;
            px.blue  = last_queued.blue  + 8'($urandom_range(6)) - 8'd3;
        end
        else
        begin
            px.red   = random_channel();
            px.green = random_channel();
            px.blue  = random_channel();
        end
        return px;
    endfunction

    // One pixel in the batch may be marked to hold the sender until the block is empty.
    task automatic queue_random(input int unsigned count, input bit with_pause);
        int unsigned pause_at;
        pause_at = with_pause ? $urandom_range(count - 1) : count;
        for (int unsigned i = 0; i < count; i++)
            queue_pixel(random_pixel(), i == pause_at && i != 0);
    endtask

    // Returns once every queued pixel was taken and every residual word arrived.
    task automatic settle();
        do @(negedge clk);
        while (pixel_queue.size() != 0 || pixel_valid || residual_due.size() != 0);
    endtask

    task automatic set_idling(input int mode);
        sender_idle_pct    = SENDER_IDLE_PCT[mode];
        receiver_stall_pct = RECEIVER_STALL_PCT[mode];
    endtask

    function automatic logic [REG_W-1:0] pick_width();
        case ($urandom_range(10))
            0:             return '0;
            1:             return REG_ONE;
            2:             return REG_MAX;
            3, 4, 5, 6:    return REG_W'($urandom_range(2, 8));
            7, 8:          return REG_W'($urandom_range(9, 64));
            9:             return REG_W'($urandom_range(65, 300));
            default:       return WIDTH_LIMIT;
        endcase
    endfunction

    function automatic logic [REG_W-1:0] pick_height();
        case ($urandom_range(9))
            0:             return '0;
            1:             return REG_MAX;
            2:             return HEIGHT_LIMIT;
            3, 4, 5, 6:    return REG_W'($urandom_range(1, 4));
            default:       return REG_W'($urandom_range(5, 8));
        endcase
    endfunction

    // Pixels still needed to finish the image under the current sizes.
    function automatic int unsigned pixels_to_image_end();
        int unsigned row_len;
        int unsigned row_count;
        int unsigned row_left;
        int unsigned rows_after;
        row_len    = span(width_setting, MAX_WIDTH);
        row_count  = span(height_setting, MAX_ROWS);
        row_left   = (column_at + 1 >= row_len) ? 1 : row_len - column_at;
        rows_after = (row_at + 1 >= row_count) ? 0 : row_count - row_at - 1;
        return row_left + rows_after * row_len;
    endfunction

    initial
    begin
        int unsigned random_sent;
        int unsigned phase_index;
        int unsigned count;

        set_idling(0);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // With the reset sizes, every pixel is a whole image: predicted as black.
        queue_pixel(in_word_t'(24'h000000), 1'b0);
        queue_pixel(in_word_t'(24'hFFFFFF), 1'b0);
        settle();

        // A 3 x 2 image and half of the next one. This covers the left, upper and
        // gradient predictors, and the wrap back to the top.
        write_width(REG_W'(3));
        write_register(CFG_IMAGE_HEIGHT, REG_W'(2));
        foreach (GRID_PIXELS[i])
            queue_pixel(in_word_t'(GRID_PIXELS[i]), 1'b0);
        settle();

        // Sizes of zero written at the start of the second row. The next pixel is past
        // both new limits, so it closes the row and the image at once. Writes to an
        // index with no register behind it must change nothing.
        write_width('0);
        write_register(CFG_IMAGE_HEIGHT, '0);
        write_spare_register();
        queue_pixel(in_word_t'(24'h00FF00), 1'b0);
        queue_pixel(in_word_t'(24'hFF00FF), 1'b0);
        settle();

        // A long first row with both registers at their all-ones value, so the width
        // acts as the limit. Then the sizes are cut part-way through that row, which
        // ends the row on the current pixel. The second row of a 3 x 2 image follows.
        set_idling(3);
        write_width(REG_MAX);
        write_register(CFG_IMAGE_HEIGHT, REG_MAX);
        queue_random(LONG_ROW_PIXELS, 1'b0);
        settle();
        write_width(REG_W'(3));
        write_register(CFG_IMAGE_HEIGHT, REG_W'(2));
        queue_random(4, 1'b0);
        settle();

        // Random phases. Most run to the end of an image, or several images. The rest
        // stop part-way, so that the next size change lands in the middle of an image.
        random_sent = 0;
        phase_index = 0;
        while (random_sent < RANDOM_PIXELS)
        begin
            set_idling(phase_index % 4);
            if ($urandom_range(3) != 0)
                write_width(pick_width());
            if ($urandom_range(3) != 0)
                write_register(CFG_IMAGE_HEIGHT, pick_height());
            if ($urandom_range(9) == 0)
                write_spare_register();

            count = pixels_to_image_end() + $urandom_range(2) *
                    span(width_setting, MAX_WIDTH) * span(height_setting, MAX_ROWS);
            if ($urandom_range(3) == 0 || count > WHOLE_IMAGE_CAP)
                count = $urandom_range(1, 40);
            queue_random(count, phase_index % 3 == 1);
            settle();
            random_sent += count;
            phase_index++;
        end

        // Let the clock run on for TAIL_CYCLES, so that any word the block should not produce shows up.
        set_idling(0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (residual_due.size() != 0)
            note_error($sformatf("%0d residual words expected, got none",
                                 residual_due.size()));

        if (mismatch_count == 0)
            $display("lossless_pixel_residual_transform_unit_test: done, clean");
        else
            $display("lossless_pixel_residual_transform_unit_test: done, errors");
        $finish;
    end

    // Watchdog, set far beyond the slowest correct run.
    initial
    begin
        #(10_000_000);
        $display("lossless_pixel_residual_transform_unit_test: done, errors");
        $finish;
    end

endmodule
